// ----- sv/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NUM_SWITCHES = 5;
    localparam int SW_SLOTS     = 5;
    localparam int TIMER_WIDTH  = 12;
    localparam int LIMIT_WIDTH  = 12;
    localparam int BOUNCE_WIDTH = 8;
    localparam int EVENT_WIDTH  = 3;
    // wide enough for every timer, limit and debounce comparison
    localparam int CMP_WIDTH    = 17;

    localparam int IN_DATA_WIDTH  = 16;
    localparam int OUT_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 12;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOUNCE      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SHORT_LIMIT = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_LIMIT  = 2'd2;

    localparam logic [BOUNCE_WIDTH-1:0] BOUNCE_RESET      = 8'd10;
    localparam logic [LIMIT_WIDTH-1:0]  SHORT_LIMIT_RESET = 12'd1000;
    localparam logic [LIMIT_WIDTH-1:0]  LONG_LIMIT_RESET  = 12'd2000;

    typedef enum logic [6:0] {
        PH_IDLE              = 7'b000_0001,
        PH_PRESSED           = 7'b000_0010,
        PH_WAIT_BOUNCE       = 7'b000_0100,
        PH_CONFIRMED         = 7'b000_1000,
        PH_WAIT_RELEASE      = 7'b001_0000,
        PH_WAIT_RELEASE_LONG = 7'b010_0000,
        PH_BOUNCE_RELEASE    = 7'b100_0000
    } t_phase;

    typedef enum logic [EVENT_WIDTH-1:0] {
        EV_IDLE          = 3'd0,
        EV_JUST_PRESSED  = 3'd1,
        EV_SHORT         = 3'd2,
        EV_LONG          = 3'd3,
        EV_JUST_RELEASED = 3'd4
    } t_event;

    typedef struct packed {
        logic [BOUNCE_WIDTH-1:0] bounce;
        logic [LIMIT_WIDTH-1:0]  short_limit;
        logic [LIMIT_WIDTH-1:0]  long_limit;
    } t_cfg;

    typedef struct packed {
        t_phase                 phase;
        logic [TIMER_WIDTH-1:0] timer;
        t_event                 evt;
    } t_sw_state;

endpackage

// ----- sv/bpc_switch.sv -----
// ----------------------------------------------------------------------------
// bpc_switch
// Next-state logic of one switch: timer tick, event clear, one phase step.
// ----------------------------------------------------------------------------
module bpc_switch (
    input  bpc_pkg::t_cfg      i_cfg,
    input  bpc_pkg::t_sw_state i_state,
    input  logic               i_tick,
    input  logic               i_pressed,
    input  logic               i_clear,
    output bpc_pkg::t_sw_state o_state
);

    logic [bpc_pkg::TIMER_WIDTH-1:0] timer_t;
    logic [bpc_pkg::CMP_WIDTH-1:0]   timer_x;
    logic [bpc_pkg::CMP_WIDTH-1:0]   bounce_x;
    logic [bpc_pkg::CMP_WIDTH-1:0]   short_x;
    logic [bpc_pkg::CMP_WIDTH-1:0]   long_x;
    logic [bpc_pkg::CMP_WIDTH-1:0]   cur_x;
    logic                            can_count;
    logic                            bounce_done;
    bpc_pkg::t_event                 evt_c;

    assign long_x   = bpc_pkg::CMP_WIDTH'(i_cfg.long_limit);
    assign short_x  = bpc_pkg::CMP_WIDTH'(i_cfg.short_limit);
    assign bounce_x = bpc_pkg::CMP_WIDTH'(i_cfg.bounce);
    assign cur_x    = bpc_pkg::CMP_WIDTH'(i_state.timer);

    // saturate one above the long limit, and never past the all-ones value
    assign can_count = (cur_x <= long_x) && (i_state.timer != bpc_pkg::TIMER_MAX);
    assign timer_t   = (i_tick && can_count) ?
                       bpc_pkg::TIMER_WIDTH'(i_state.timer + 1'b1) : i_state.timer;
    assign timer_x   = bpc_pkg::CMP_WIDTH'(timer_t);
    assign bounce_done = (timer_x >= bounce_x);
    assign evt_c     = i_clear ? bpc_pkg::EV_IDLE : i_state.evt;

    always_comb begin
        o_state.phase = i_state.phase;
        o_state.timer = timer_t;
        o_state.evt   = evt_c;
        case (i_state.phase)
            bpc_pkg::PH_PRESSED: begin
                o_state.timer = '0;
                o_state.phase = bpc_pkg::PH_WAIT_BOUNCE;
            end
            bpc_pkg::PH_WAIT_BOUNCE: begin
                if (bounce_done) begin
                    o_state.phase = i_pressed ? bpc_pkg::PH_CONFIRMED : bpc_pkg::PH_IDLE;
                end else if (!i_pressed) begin
                    o_state.phase = bpc_pkg::PH_IDLE;
                end
            end
            bpc_pkg::PH_CONFIRMED: begin
                o_state.timer = '0;
                o_state.phase = bpc_pkg::PH_WAIT_RELEASE;
                o_state.evt   = bpc_pkg::EV_JUST_PRESSED;
            end
            bpc_pkg::PH_WAIT_RELEASE: begin
                if (!i_pressed) begin
                    o_state.evt   = (timer_x < short_x) ? bpc_pkg::EV_SHORT : bpc_pkg::EV_LONG;
                    o_state.timer = '0;
                    o_state.phase = bpc_pkg::PH_BOUNCE_RELEASE;
                end else if (timer_x > long_x) begin
                    // declare long before release
                    o_state.evt   = bpc_pkg::EV_LONG;
                    o_state.phase = bpc_pkg::PH_WAIT_RELEASE_LONG;
                end
            end
            bpc_pkg::PH_WAIT_RELEASE_LONG: begin
                if (!i_pressed) begin
                    o_state.timer = '0;
                    o_state.phase = bpc_pkg::PH_BOUNCE_RELEASE;
                end
            end
            bpc_pkg::PH_BOUNCE_RELEASE: begin
                if (bounce_done) begin
                    o_state.evt   = bpc_pkg::EV_JUST_RELEASED;
                    o_state.phase = bpc_pkg::PH_IDLE;
                end
            end
            default: begin
                o_state.phase = i_pressed ? bpc_pkg::PH_PRESSED : bpc_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/button_press_classifier_top.sv -----
// ----------------------------------------------------------------------------
// button_press_classifier_top
// Debounced short/long press classifier for five active-low switches.
// ----------------------------------------------------------------------------
// Each poll transfer advances every switch by one step and yields one result
// transfer with all latched event codes. The block takes one poll per clock
// while the output side is not stalled; a poll passes through the input
// register, then the result register, where the per-switch compare-and-update
// logic sits between them. Switch state is updated as a poll moves into the
// result register, so stalls on the output side hold the input register and no
// state changes. Configuration writes are taken at any time and are meant for
// an idle block.
module button_press_classifier_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // poll input: [0] ms_tick, [5:1] switch_levels, [10:6] clear_mask
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [bpc_pkg::IN_DATA_WIDTH-1:0]    i_s_axis_tdata,
    // events: [2:0] event_sw0, [5:3] event_sw1, [8:6] event_sw2,
    // [11:9] event_sw3, [14:12] event_sw4
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [bpc_pkg::OUT_DATA_WIDTH-1:0]   o_m_axis_tdata,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int NSW = bpc_pkg::NUM_SWITCHES;

    bpc_pkg::t_cfg      r_cfg;
    bpc_pkg::t_sw_state r_state [NSW];
    bpc_pkg::t_sw_state n_state [NSW];

    logic                              r_in_valid;
    logic                              r_in_tick;
    logic [bpc_pkg::SW_SLOTS-1:0]      r_in_levels;
    logic [bpc_pkg::SW_SLOTS-1:0]      r_in_clear;
    logic                              r_out_valid;
    logic [bpc_pkg::OUT_DATA_WIDTH-1:0] r_out_data;
    logic [bpc_pkg::OUT_DATA_WIDTH-1:0] n_out_data;
    logic                              advance;

    assign o_cfg_ready     = 1'b1;
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bounce      <= bpc_pkg::BOUNCE_RESET;
            r_cfg.short_limit <= bpc_pkg::SHORT_LIMIT_RESET;
            r_cfg.long_limit  <= bpc_pkg::LONG_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpc_pkg::CFG_BOUNCE:      r_cfg.bounce <= i_cfg_data[bpc_pkg::BOUNCE_WIDTH-1:0];
                bpc_pkg::CFG_SHORT_LIMIT: r_cfg.short_limit <= i_cfg_data;
                bpc_pkg::CFG_LONG_LIMIT:  r_cfg.long_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < NSW; g++) begin : g_sw
            bpc_switch u_switch (
                .i_cfg     (r_cfg),
                .i_state   (r_state[g]),
                .i_tick    (r_in_tick),
                .i_pressed (!r_in_levels[g]),
                .i_clear   (r_in_clear[g]),
                .o_state   (n_state[g])
            );
        end
    endgenerate

    always_comb begin
        n_out_data = '0;
        for (int i = 0; i < NSW; i++) begin
            n_out_data[i*bpc_pkg::EVENT_WIDTH +: bpc_pkg::EVENT_WIDTH] = n_state[i].evt;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_tick   <= i_s_axis_tdata[0];
            r_in_levels <= i_s_axis_tdata[5:1];
            r_in_clear  <= i_s_axis_tdata[10:6];
        end
    end

    // switch state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < NSW; i++) begin
                r_state[i].phase <= bpc_pkg::PH_IDLE;
                r_state[i].timer <= '0;
                r_state[i].evt   <= bpc_pkg::EV_IDLE;
            end
        end else if (advance) begin
            r_out_valid <= 1'b1;
            for (int i = 0; i < NSW; i++) begin
                r_state[i] <= n_state[i];
            end
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_rise_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a held poll");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled while result register empty");

    a_held_poll_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=>
            (r_in_valid && $stable(r_in_levels) && $stable(r_in_clear) && $stable(r_in_tick)))
        else $error("stalled poll changed");

    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state[0]))
        else $error("switch state moved without a poll");
`endif

endmodule

// ----- test/tb_button_press_classifier_top.sv -----
// ----------------------------------------------------------------------------
// tb_button_press_classifier_top
// Self-checking testbench of the debounced short/long press classifier.
// ----------------------------------------------------------------------------
// Polls are sent over the input stream with random gaps. A cycle-level model
// of the five switch machines predicts the event word of every accepted poll.
// Each result transfer is checked field by field against the oldest
// prediction. The run goes through the reset settings, the low and high ends
// of the registers, a debounce longer than the timer cap, several random small
// settings, and a long output stall that backs up the input.
module tb_button_press_classifier_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_GAP     = 18;
    localparam int RES_WIDTH   = bpc_pkg::SW_SLOTS * bpc_pkg::EVENT_WIDTH;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_s_axis_tvalid;
    logic                               o_s_axis_tready;
    logic [bpc_pkg::IN_DATA_WIDTH-1:0]  i_s_axis_tdata;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready;
    logic [bpc_pkg::OUT_DATA_WIDTH-1:0] o_m_axis_tdata;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [bpc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index;
    logic [bpc_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data;

    button_press_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // switch model and its settings
    bpc_pkg::t_phase                  sw_phase [bpc_pkg::SW_SLOTS];
    logic [bpc_pkg::TIMER_WIDTH-1:0]  sw_timer [bpc_pkg::SW_SLOTS];
    bpc_pkg::t_event                  sw_event [bpc_pkg::SW_SLOTS];
    logic [bpc_pkg::BOUNCE_WIDTH-1:0] bounce_ticks;
    logic [bpc_pkg::LIMIT_WIDTH-1:0]  short_limit;
    logic [bpc_pkg::LIMIT_WIDTH-1:0]  long_limit;

    logic [RES_WIDTH-1:0] event_words_q [$];

    int   mismatches;
    int   unexpected;
    int   cycles;
    bit   no_idle;
    bit   hold_req;
    logic [bpc_pkg::SW_SLOTS-1:0] held;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [RES_WIDTH-1:0] classify_poll(
            input logic                         tick,
            input logic [bpc_pkg::SW_SLOTS-1:0] levels,
            input logic [bpc_pkg::SW_SLOTS-1:0] clr);
        int                   cap;
        logic                 pressed;
        logic [RES_WIDTH-1:0] word;
        cap = int'(long_limit) + 1;
        if (cap > int'(bpc_pkg::TIMER_MAX))
            cap = int'(bpc_pkg::TIMER_MAX);
        if (tick) begin
            for (int i = 0; i < bpc_pkg::NUM_SWITCHES; i++)
                if (sw_timer[i] <= long_limit && int'(sw_timer[i]) < cap)
                    sw_timer[i] = sw_timer[i] + 1'b1;
        end
        for (int i = 0; i < bpc_pkg::NUM_SWITCHES; i++)
            if (clr[i])
                sw_event[i] = bpc_pkg::EV_IDLE;
        for (int i = 0; i < bpc_pkg::NUM_SWITCHES; i++) begin
            pressed = ~levels[i];
            case (sw_phase[i])
                bpc_pkg::PH_PRESSED: begin
                    sw_timer[i] = '0;
                    sw_phase[i] = bpc_pkg::PH_WAIT_BOUNCE;
                end
                bpc_pkg::PH_WAIT_BOUNCE: begin
                    if (sw_timer[i] >= bounce_ticks) begin
                        if (pressed)
                            sw_phase[i] = bpc_pkg::PH_CONFIRMED;
                        else
                            sw_phase[i] = bpc_pkg::PH_IDLE;
                    end else if (!pressed) begin
                        sw_phase[i] = bpc_pkg::PH_IDLE;
                    end
                end
                bpc_pkg::PH_CONFIRMED: begin
                    sw_timer[i] = '0;
                    sw_phase[i] = bpc_pkg::PH_WAIT_RELEASE;
                    sw_event[i] = bpc_pkg::EV_JUST_PRESSED;
                end
                bpc_pkg::PH_WAIT_RELEASE: begin
                    if (!pressed) begin
                        if (sw_timer[i] < short_limit)
                            sw_event[i] = bpc_pkg::EV_SHORT;
                        else
                            sw_event[i] = bpc_pkg::EV_LONG;
                        sw_timer[i] = '0;
                        sw_phase[i] = bpc_pkg::PH_BOUNCE_RELEASE;
                    end else if (sw_timer[i] > long_limit) begin
                        sw_event[i] = bpc_pkg::EV_LONG;
                        sw_phase[i] = bpc_pkg::PH_WAIT_RELEASE_LONG;
                    end
                end
                bpc_pkg::PH_WAIT_RELEASE_LONG: begin
                    if (!pressed) begin
                        sw_timer[i] = '0;
                        sw_phase[i] = bpc_pkg::PH_BOUNCE_RELEASE;
                    end
                end
                bpc_pkg::PH_BOUNCE_RELEASE: begin
                    if (sw_timer[i] >= bounce_ticks) begin
                        sw_event[i] = bpc_pkg::EV_JUST_RELEASED;
                        sw_phase[i] = bpc_pkg::PH_IDLE;
                    end
                end
                default: begin
                    if (pressed)
                        sw_phase[i] = bpc_pkg::PH_PRESSED;
                    else
                        sw_phase[i] = bpc_pkg::PH_IDLE;
                end
            endcase
        end
        word = '0;
        for (int i = 0; i < bpc_pkg::NUM_SWITCHES; i++)
            word[i*bpc_pkg::EVENT_WIDTH +: bpc_pkg::EVENT_WIDTH] = sw_event[i];
        return word;
    endfunction

    task automatic send_poll(input logic tick, input logic [bpc_pkg::SW_SLOTS-1:0] levels,
                             input logic [bpc_pkg::SW_SLOTS-1:0] clr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {5'b0, clr, levels, tick};
        do @(posedge i_clk); while (!o_s_axis_tready);
        event_words_q.push_back(classify_poll(tick, levels, clr));
    endtask

    task automatic drop_poll();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (event_words_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg_reg(input logic [bpc_pkg::CFG_IDX_WIDTH-1:0] idx,
                                 input logic [bpc_pkg::CFG_DATA_WIDTH-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            bpc_pkg::CFG_BOUNCE:      bounce_ticks = value[bpc_pkg::BOUNCE_WIDTH-1:0];
            bpc_pkg::CFG_SHORT_LIMIT: short_limit  = value;
            bpc_pkg::CFG_LONG_LIMIT:  long_limit   = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input int bounce, input int short_ms, input int long_ms);
        write_cfg_reg(bpc_pkg::CFG_BOUNCE, bpc_pkg::CFG_DATA_WIDTH'(bounce));
        write_cfg_reg(bpc_pkg::CFG_SHORT_LIMIT, bpc_pkg::CFG_DATA_WIDTH'(short_ms));
        write_cfg_reg(bpc_pkg::CFG_LONG_LIMIT, bpc_pkg::CFG_DATA_WIDTH'(long_ms));
    endtask

    // Random walk of held switches, with single-poll contact bounce on top.
    task automatic random_polls(input int count);
        logic [bpc_pkg::SW_SLOTS-1:0] noise;
        logic [bpc_pkg::SW_SLOTS-1:0] clr;
        logic                         tick;
        for (int k = 0; k < count; k++) begin
            for (int s = 0; s < bpc_pkg::SW_SLOTS; s++)
                if ($urandom_range(0, 11) == 0)
                    held[s] = ~held[s];
            noise = '0;
            if ($urandom_range(0, 19) == 0)
                noise[$urandom_range(0, bpc_pkg::SW_SLOTS-1)] = 1'b1;
            tick = ($urandom_range(0, 9) < 7);
            clr  = ($urandom_range(0, 5) == 0) ? bpc_pkg::SW_SLOTS'($urandom) : '0;
            send_poll(tick, ~held ^ noise, clr);
        end
        drop_poll();
    endtask

    // Reset settings: press all, get just-pressed, release under a full clear
    // (the short event latched in that step survives), then just-released.
    task automatic test_reset_settings();
        send_poll(1'b0, 5'h1F, 5'h00);
        for (int k = 0; k < 13; k++)
            send_poll(1'b1, 5'h00, 5'h00);
        send_poll(1'b1, 5'h1F, 5'h1F);
        for (int k = 0; k < 11; k++)
            send_poll(1'b1, 5'h1F, 5'h00);
        drop_poll();
    endtask

    task automatic test_low_limits();
        set_limits(1, 1, 1);
        random_polls(60);
    endtask

    // debounce longer than the timer cap never completes
    task automatic test_bounce_past_cap();
        set_limits(255, 4094, 1);
        random_polls(40);
    endtask

    task automatic test_high_limits();
        set_limits(255, 4094, 4094);
        random_polls(30);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 6; p++) begin
            set_limits($urandom_range(1, 4), $urandom_range(1, 10), $urandom_range(1, 16));
            no_idle = (p == 2);
            random_polls(45);
            no_idle = 1'b0;
        end
    endtask

    task automatic test_output_stall();
        set_limits(2, 4, 8);
        hold_req = 1'b1;
        no_idle  = 1'b1;
        random_polls(30);
        no_idle  = 1'b0;
    endtask

    // result receiver
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        logic [RES_WIDTH-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (event_words_q.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("result with no prediction: %h", o_m_axis_tdata);
            end else begin
                want = event_words_q.pop_front();
                for (int i = 0; i < bpc_pkg::SW_SLOTS; i++) begin
                    if (o_m_axis_tdata[i*bpc_pkg::EVENT_WIDTH +: bpc_pkg::EVENT_WIDTH]
                            !== want[i*bpc_pkg::EVENT_WIDTH +: bpc_pkg::EVENT_WIDTH]) begin
                        mismatches++;
                        if (mismatches + unexpected <= 10)
                            $display("event_sw%0d mismatch: expected %0d, got %0d", i,
                                     want[i*bpc_pkg::EVENT_WIDTH +: bpc_pkg::EVENT_WIDTH],
                                     o_m_axis_tdata[i*bpc_pkg::EVENT_WIDTH +:
                                                    bpc_pkg::EVENT_WIDTH]);
                    end
                end
            end
        end
    end

    initial begin
        mismatches      = 0;
        unexpected      = 0;
        cycles          = 0;
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        held            = '0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = bpc_pkg::CFG_BOUNCE;
        i_cfg_data      = '0;
        bounce_ticks    = bpc_pkg::BOUNCE_RESET;
        short_limit     = bpc_pkg::SHORT_LIMIT_RESET;
        long_limit      = bpc_pkg::LONG_LIMIT_RESET;
        for (int i = 0; i < bpc_pkg::SW_SLOTS; i++) begin
            sw_phase[i] = bpc_pkg::PH_IDLE;
            sw_timer[i] = '0;
            sw_event[i] = bpc_pkg::EV_IDLE;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_settings();
        test_low_limits();
        test_bounce_past_cap();
        test_high_limits();
        test_random_settings();
        test_output_stall();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && unexpected == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/bpc_pkg.sv
sv/bpc_switch.sv
sv/button_press_classifier_top.sv
test/tb_button_press_classifier_top.sv
